@@ sv/igelu_pkg.sv @@
// ----------------------------------------------------------------------------
// igelu_pkg
// Shared widths, constants, types and the erf polynomial table for the
// int8 GELU pipeline.
// ----------------------------------------------------------------------------
package igelu_pkg;

    // Port and field widths
    localparam int SAMPLE_W  = 8;
    localparam int ACT_W     = 8;
    localparam int SCALE_W   = 32;
    localparam int CLAMP_W   = 8;
    localparam int CFG_IDX_W = 2;

    // Internal datapath widths
    localparam int FA_W       = 39;   // |x| * input_scale, Q15.24 magnitude
    localparam int FA_SMALL_W = 27;   // |f| < 8.0 in Q24
    localparam int Z_W        = 27;   // |f| / sqrt2, Q24
    localparam int Z_FRAC     = 24;
    localparam int P_W        = 35;   // polynomial value, Q32, below 8.0
    localparam int R_W        = 32;   // reciprocal powers, Q31, at most 1.0
    localparam int SQ_FRAC    = 31;
    localparam int PHI_W      = 33;   // Phi, Q32, up to and including 1.0
    localparam int PHI_SHIFT  = 16;
    localparam int Y_W        = 55;   // GELU magnitude, Q40
    localparam int PL_W       = 32 + SCALE_W;
    localparam int PH_W       = (Y_W - 32) + SCALE_W;
    localparam int PROD_W     = Y_W + SCALE_W;
    localparam int RQ_FRAC    = 56;
    localparam int PH_TOP_W   = PROD_W - RQ_FRAC + 1;
    localparam int MAG_W      = 9;
    localparam int V_W        = MAG_W + 1;

    // Pipeline shape
    localparam int HORNER_STEPS        = 6;
    localparam int DIV_BITS            = 32;
    localparam int DIV_STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES          = DIV_BITS / DIV_STEPS_PER_STAGE;
    localparam int SQUARINGS           = 4;
    localparam int FRONT_STAGES        = 2;
    localparam int REQUANT_STAGES      = 6;
    localparam int LATENCY             = FRONT_STAGES + HORNER_STEPS + DIV_STAGES
                                         + SQUARINGS + REQUANT_STAGES;

    // Arithmetic constants
    localparam logic [31:0]      SQRT_HALF_Q32 = 32'd3037000500;
    localparam logic [P_W-1:0]   ONE_Q32       = P_W'(64'h1_0000_0000);
    localparam logic [PHI_W-1:0] PHI_ONE       = PHI_W'(64'h1_0000_0000);
    localparam logic [PHI_W-1:0] PHI_HALF      = PHI_W'(64'h8000_0000);
    localparam logic [R_W-1:0]   R_MAX         = R_W'(64'h8000_0000);
    localparam logic [2*R_W-1:0] SQ_ROUND      = (2*R_W)'(64'd1 << (SQ_FRAC - 1));
    localparam logic [MAG_W-1:0] MAG_SAT       = MAG_W'(256);

    localparam logic signed [V_W-1:0] ACT_MAX_V = V_W'((2 ** (ACT_W - 1)) - 1);
    localparam logic signed [V_W-1:0] ACT_MIN_V = -ACT_MAX_V - V_W'(1);

    // Abramowitz-Stegun 7.1.28 coefficients, floor(a_k * 2^32)
    localparam logic [63:0]    ERF_DEN = 64'd10000000000;
    localparam logic [P_W-1:0] ERF_A1  = P_W'((64'd705230784 << 32) / ERF_DEN);
    localparam logic [P_W-1:0] ERF_A2  = P_W'((64'd422820123 << 32) / ERF_DEN);
    localparam logic [P_W-1:0] ERF_A3  = P_W'((64'd92705272 << 32) / ERF_DEN);
    localparam logic [P_W-1:0] ERF_A4  = P_W'((64'd1520143 << 32) / ERF_DEN);
    localparam logic [P_W-1:0] ERF_A5  = P_W'((64'd2765672 << 32) / ERF_DEN);
    localparam logic [P_W-1:0] ERF_A6  = P_W'((64'd430638 << 32) / ERF_DEN);

    localparam logic [P_W-1:0] HORNER_INIT = ERF_A6;

    // Register reset values
    localparam logic [SCALE_W-1:0]        INPUT_SCALE_RST   = 32'h0100_0000;
    localparam logic [SCALE_W-1:0]        INV_OUT_SCALE_RST = 32'h0001_0000;
    localparam logic signed [CLAMP_W-1:0] CLAMP_LOW_RST     = -8'sd128;
    localparam logic signed [CLAMP_W-1:0] CLAMP_HIGH_RST    = 8'sd127;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INPUT_SCALE   = 2'd0,
        CFG_INV_OUT_SCALE = 2'd1,
        CFG_CLAMP_LOW     = 2'd2,
        CFG_CLAMP_HIGH    = 2'd3
    } cfg_index_t;

    // Per-request sideband that rides along the pipeline
    typedef struct packed {
        logic [FA_W-1:0] fa;
        logic            neg;
        logic            big;
        logic            last;
    } igelu_side_t;

    // Constant added after Horner step k
    function automatic logic [P_W-1:0] horner_add(input int step);
        logic [P_W-1:0] c;
        case (step)
            0:       c = ERF_A5;
            1:       c = ERF_A4;
            2:       c = ERF_A3;
            3:       c = ERF_A2;
            4:       c = ERF_A1;
            default: c = ONE_Q32;
        endcase
        return c;
    endfunction

endpackage

@@ sv/igelu_front.sv @@
// ----------------------------------------------------------------------------
// igelu_front
// Dequantisation: magnitude of the sample times the input scale, then the
// scaled erf argument z = |f| / sqrt2 and the large-magnitude flag.
// ----------------------------------------------------------------------------
module igelu_front
    import igelu_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                       last_in,
    input  logic [SCALE_W-1:0]         input_scale,
    output logic                       out_valid,
    output logic [Z_W-1:0]             z,
    output igelu_side_t                side
);

    logic [SAMPLE_W-1:0]         mag;
    logic [SAMPLE_W+SCALE_W-1:0] fa_prod;
    logic [FA_W-1:0]             fa_next;
    logic [FA_W-1:0]             fa_reg;
    logic                        neg_reg;
    logic                        last_reg;
    logic                        valid1_reg;

    logic [FA_SMALL_W+32-1:0]    z_prod;
    logic [Z_W-1:0]              z_next;
    logic [Z_W-1:0]              z_reg;
    igelu_side_t                 side_next;
    igelu_side_t                 side_reg;
    logic                        valid2_reg;

    // -128 maps to 8'h80, which is 128 as unsigned
    assign mag     = sample[SAMPLE_W-1] ? ((~sample) + SAMPLE_W'(1)) : sample;
    assign fa_prod = (SAMPLE_W+SCALE_W)'(mag) * (SAMPLE_W+SCALE_W)'(input_scale);
    assign fa_next = fa_prod[FA_W-1:0];

    assign z_prod = (FA_SMALL_W+32)'(fa_reg[FA_SMALL_W-1:0])
                  * (FA_SMALL_W+32)'(SQRT_HALF_Q32);
    assign z_next = z_prod[FA_SMALL_W+31:32];

    always_comb
    begin
        side_next.fa   = fa_reg;
        side_next.neg  = neg_reg;
        side_next.big  = |fa_reg[FA_W-1:FA_SMALL_W];
        side_next.last = last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end
        else
        begin
            valid1_reg <= in_valid;
            valid2_reg <= valid1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        fa_reg   <= fa_next;
        neg_reg  <= sample[SAMPLE_W-1];
        last_reg <= last_in;
        z_reg    <= z_next;
        side_reg <= side_next;
    end

    assign out_valid = valid2_reg;
    assign z         = z_reg;
    assign side      = side_reg;

endmodule

@@ sv/igelu_poly.sv @@
// ----------------------------------------------------------------------------
// igelu_poly
// Horner evaluation of P(z) = 1 + a1 z + ... + a6 z^6 in Q32, one
// multiply-add per stage.
// ----------------------------------------------------------------------------
module igelu_poly
    import igelu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [Z_W-1:0]   z,
    input  igelu_side_t      side_in,
    output logic             out_valid,
    output logic [P_W-1:0]   poly,
    output igelu_side_t      side_out
);

    localparam int PROD_W = P_W + Z_W;
    localparam int SUM_W  = PROD_W - Z_FRAC + 1;

    logic [P_W-1:0]          acc_src  [HORNER_STEPS];
    logic [Z_W-1:0]          z_src    [HORNER_STEPS];
    logic [PROD_W-1:0]       prod     [HORNER_STEPS];
    logic [SUM_W-1:0]        sum      [HORNER_STEPS];
    logic [P_W-1:0]          acc_next [HORNER_STEPS];
    logic [P_W-1:0]          acc_reg  [HORNER_STEPS];
    logic [Z_W-1:0]          z_reg    [HORNER_STEPS-1];
    igelu_side_t             side_reg [HORNER_STEPS];
    logic [HORNER_STEPS-1:0] valid_reg;

    always_comb
    begin
        acc_src[0] = HORNER_INIT;
        z_src[0]   = z;
        for (int k = 1; k < HORNER_STEPS; k++)
        begin
            acc_src[k] = acc_reg[k-1];
            z_src[k]   = z_reg[k-1];
        end
        for (int k = 0; k < HORNER_STEPS; k++)
        begin
            prod[k]     = PROD_W'(acc_src[k]) * PROD_W'(z_src[k]);
            sum[k]      = SUM_W'(prod[k][PROD_W-1:Z_FRAC]) + SUM_W'(horner_add(k));
            // every partial sum stays below 8.0 for |f| < 8
            acc_next[k] = sum[k][P_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[HORNER_STEPS-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_in;
        for (int k = 0; k < HORNER_STEPS; k++)
        begin
            acc_reg[k] <= acc_next[k];
        end
        for (int k = 0; k < HORNER_STEPS - 1; k++)
        begin
            z_reg[k] <= z_src[k];
        end
        for (int k = 1; k < HORNER_STEPS; k++)
        begin
            side_reg[k] <= side_reg[k-1];
        end
    end

    assign out_valid = valid_reg[HORNER_STEPS-1];
    assign poly      = acc_reg[HORNER_STEPS-1];
    assign side_out  = side_reg[HORNER_STEPS-1];

endmodule

@@ sv/igelu_recip.sv @@
// ----------------------------------------------------------------------------
// igelu_recip
// Rounded reciprocal R = round(2^63 / P) by a pipelined restoring divider,
// then four squarings in Q31 to give P^-16.
// ----------------------------------------------------------------------------
module igelu_recip
    import igelu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [P_W-1:0]   poly,
    input  igelu_side_t      side_in,
    output logic             out_valid,
    output logic [R_W-1:0]   recip16,
    output igelu_side_t      side_out
);

    localparam int TRIAL_W = P_W + 1;

    // Divider
    logic [P_W-1:0]        rem_init;
    logic [DIV_BITS-1:0]   num_init;
    logic [P_W-1:0]        rem_src  [DIV_STAGES];
    logic [DIV_BITS-1:0]   num_src  [DIV_STAGES];
    logic [R_W-1:0]        q_src    [DIV_STAGES];
    logic [P_W-1:0]        den_src  [DIV_STAGES];
    logic [P_W-1:0]        rem_next [DIV_STAGES];
    logic [DIV_BITS-1:0]   num_next [DIV_STAGES];
    logic [R_W-1:0]        q_next   [DIV_STAGES];
    logic [P_W-1:0]        rem_reg  [DIV_STAGES];
    logic [DIV_BITS-1:0]   num_reg  [DIV_STAGES];
    logic [R_W-1:0]        q_reg    [DIV_STAGES];
    logic [P_W-1:0]        den_reg  [DIV_STAGES];
    igelu_side_t           div_side_reg [DIV_STAGES];
    logic [DIV_STAGES-1:0] div_valid_reg;

    // Squarings
    logic [R_W-1:0]        sq_src  [SQUARINGS];
    logic [2*R_W-1:0]      sq_prod [SQUARINGS];
    logic [R_W-1:0]        sq_next [SQUARINGS];
    logic [R_W-1:0]        sq_reg  [SQUARINGS];
    igelu_side_t           sq_side_reg [SQUARINGS];
    logic [SQUARINGS-1:0]  sq_valid_reg;

    // Dividend 2^63 + P/2: the two parts never overlap, so no adder
    assign rem_init = P_W'({1'b1, {(DIV_BITS-3){1'b0}}, poly[P_W-1:DIV_BITS+1]});
    assign num_init = poly[DIV_BITS:1];

    always_comb
    begin
        logic [P_W-1:0]      rem_v;
        logic [DIV_BITS-1:0] num_v;
        logic [R_W-1:0]      q_v;
        logic [TRIAL_W-1:0]  trial;

        rem_src[0] = rem_init;
        num_src[0] = num_init;
        q_src[0]   = '0;
        den_src[0] = poly;
        for (int s = 1; s < DIV_STAGES; s++)
        begin
            rem_src[s] = rem_reg[s-1];
            num_src[s] = num_reg[s-1];
            q_src[s]   = q_reg[s-1];
            den_src[s] = den_reg[s-1];
        end

        for (int s = 0; s < DIV_STAGES; s++)
        begin
            rem_v = rem_src[s];
            num_v = num_src[s];
            q_v   = q_src[s];
            for (int j = 0; j < DIV_STEPS_PER_STAGE; j++)
            begin
                trial = {rem_v, num_v[DIV_BITS-1]};
                if (trial >= {1'b0, den_src[s]})
                begin
                    trial = trial - {1'b0, den_src[s]};
                    q_v   = {q_v[R_W-2:0], 1'b1};
                end
                else
                begin
                    q_v = {q_v[R_W-2:0], 1'b0};
                end
                rem_v = trial[P_W-1:0];
                num_v = {num_v[DIV_BITS-2:0], 1'b0};
            end
            rem_next[s] = rem_v;
            num_next[s] = num_v;
            q_next[s]   = q_v;
        end
    end

    always_comb
    begin
        sq_src[0] = q_reg[DIV_STAGES-1];
        for (int i = 1; i < SQUARINGS; i++)
        begin
            sq_src[i] = sq_reg[i-1];
        end
        for (int i = 0; i < SQUARINGS; i++)
        begin
            sq_prod[i] = (2*R_W)'(sq_src[i]) * (2*R_W)'(sq_src[i]) + SQ_ROUND;
            sq_next[i] = sq_prod[i][SQ_FRAC+R_W-1:SQ_FRAC];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_valid_reg <= '0;
            sq_valid_reg  <= '0;
        end
        else
        begin
            div_valid_reg <= {div_valid_reg[DIV_STAGES-2:0], in_valid};
            sq_valid_reg  <= {sq_valid_reg[SQUARINGS-2:0], div_valid_reg[DIV_STAGES-1]};
        end
    end

    always_ff @(posedge clk)
    begin
        div_side_reg[0] <= side_in;
        sq_side_reg[0]  <= div_side_reg[DIV_STAGES-1];
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            rem_reg[s] <= rem_next[s];
            num_reg[s] <= num_next[s];
            q_reg[s]   <= q_next[s];
            den_reg[s] <= den_src[s];
        end
        for (int s = 1; s < DIV_STAGES; s++)
        begin
            div_side_reg[s] <= div_side_reg[s-1];
        end
        for (int i = 0; i < SQUARINGS; i++)
        begin
            sq_reg[i] <= sq_next[i];
        end
        for (int i = 1; i < SQUARINGS; i++)
        begin
            sq_side_reg[i] <= sq_side_reg[i-1];
        end
    end

    assign out_valid = sq_valid_reg[SQUARINGS-1];
    assign recip16   = sq_reg[SQUARINGS-1];
    assign side_out  = sq_side_reg[SQUARINGS-1];

    // P lies in [1, 8), so the reciprocal is nonzero and at most 1.0 in Q31
    a_recip_range: assert property (@(posedge clk) disable iff (!rst_n)
        div_valid_reg[DIV_STAGES-1] |->
            (q_reg[DIV_STAGES-1] <= R_MAX) && (q_reg[DIV_STAGES-1] != '0))
        else $error("reciprocal out of range");

    a_power_range: assert property (@(posedge clk) disable iff (!rst_n)
        sq_valid_reg[SQUARINGS-1] |-> sq_reg[SQUARINGS-1] <= R_MAX)
        else $error("P^-16 above 1.0");

endmodule

@@ sv/igelu_requant.sv @@
// ----------------------------------------------------------------------------
// igelu_requant
// Phi from P^-16, GELU magnitude, requantisation with rounding half away
// from zero, saturation, sign, clamping and the int8 output register.
// ----------------------------------------------------------------------------
module igelu_requant
    import igelu_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [R_W-1:0]             recip16,
    input  igelu_side_t                side_in,
    input  logic [SCALE_W-1:0]         inverse_output_scale,
    input  logic signed [CLAMP_W-1:0]  clamp_low,
    input  logic signed [CLAMP_W-1:0]  clamp_high,
    output logic                       done,
    output logic signed [ACT_W-1:0]    activation,
    output logic                       last_out
);

    localparam int YMUL_W = FA_SMALL_W + PHI_W;

    // Phi
    logic [PHI_W-1:0]          phi_next;
    logic [PHI_W-1:0]          phi_reg;
    igelu_side_t               a_side_reg;
    logic                      a_valid_reg;
    // y
    logic [YMUL_W-1:0]         ymul;
    logic [Y_W-1:0]            y_next;
    logic [Y_W-1:0]            y_reg;
    logic                      b_neg_reg;
    logic                      b_last_reg;
    logic                      b_valid_reg;
    // partial products
    logic [PL_W-1:0]           pl_next;
    logic [PH_W-1:0]           ph_next;
    logic [PL_W-1:0]           pl_reg;
    logic [PH_W-1:0]           ph_reg;
    logic                      c_neg_reg;
    logic                      c_last_reg;
    logic                      c_valid_reg;
    // full product, upper part
    logic [PROD_W-1:0]         psum;
    logic [PH_TOP_W-1:0]       ptop_next;
    logic [PH_TOP_W-1:0]       ptop_reg;
    logic                      d_neg_reg;
    logic                      d_last_reg;
    logic                      d_valid_reg;
    // rounded magnitude
    logic [PH_TOP_W:0]         rnd;
    logic [MAG_W-1:0]          mag_next;
    logic [MAG_W-1:0]          mag_reg;
    logic                      e_neg_reg;
    logic                      e_last_reg;
    logic                      e_valid_reg;
    // clamp and output
    logic signed [V_W-1:0]     lo;
    logic signed [V_W-1:0]     hi;
    logic signed [V_W-1:0]     v_mag;
    logic signed [V_W-1:0]     v_raw;
    logic signed [V_W-1:0]     v_clamp;
    logic signed [V_W-1:0]     v_sat;
    logic [ACT_W-1:0]          act_next;
    logic [ACT_W-1:0]          act_reg;
    logic                      last_reg;
    logic                      done_reg;

    assign phi_next = side_in.neg ? {1'b0, recip16} : (PHI_ONE - {1'b0, recip16});

    assign ymul = YMUL_W'(a_side_reg.fa[FA_SMALL_W-1:0]) * YMUL_W'(phi_reg);

    // Beyond |f| = 8 Phi is exactly 1 or 0
    always_comb
    begin
        if (a_side_reg.big)
        begin
            y_next = a_side_reg.neg ? '0 : {a_side_reg.fa, {PHI_SHIFT{1'b0}}};
        end
        else
        begin
            y_next = Y_W'(ymul[YMUL_W-1:PHI_SHIFT]);
        end
    end

    assign pl_next = PL_W'(y_reg[31:0]) * PL_W'(inverse_output_scale);
    assign ph_next = PH_W'(y_reg[Y_W-1:32]) * PH_W'(inverse_output_scale);

    assign psum      = PROD_W'({ph_reg, 32'b0}) + PROD_W'(pl_reg);
    assign ptop_next = psum[PROD_W-1:RQ_FRAC-1];

    // Anything at or above 2^64 rounds to 256 or above, so one saturation covers both
    assign rnd = (PH_TOP_W+1)'(ptop_reg) + (PH_TOP_W+1)'(1);

    always_comb
    begin
        if (rnd[PH_TOP_W:1] > PH_TOP_W'(MAG_SAT))
        begin
            mag_next = MAG_SAT;
        end
        else
        begin
            mag_next = rnd[MAG_W:1];
        end
    end

    assign lo = V_W'(clamp_low);
    assign hi = V_W'(clamp_high);

    always_comb
    begin
        v_mag = $signed({1'b0, mag_reg});
        v_raw = e_neg_reg ? -v_mag : v_mag;
        // when the bounds are crossed, values below the low bound give low, all others give high
        if (v_raw < lo)
        begin
            v_clamp = lo;
        end
        else if (v_raw > hi)
        begin
            v_clamp = hi;
        end
        else
        begin
            v_clamp = v_raw;
        end
        if (v_clamp < ACT_MIN_V)
        begin
            v_sat = ACT_MIN_V;
        end
        else if (v_clamp > ACT_MAX_V)
        begin
            v_sat = ACT_MAX_V;
        end
        else
        begin
            v_sat = v_clamp;
        end
        act_next = v_sat[ACT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
            done_reg    <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        phi_reg    <= phi_next;
        a_side_reg <= side_in;
        y_reg      <= y_next;
        b_neg_reg  <= a_side_reg.neg;
        b_last_reg <= a_side_reg.last;
        pl_reg     <= pl_next;
        ph_reg     <= ph_next;
        c_neg_reg  <= b_neg_reg;
        c_last_reg <= b_last_reg;
        ptop_reg   <= ptop_next;
        d_neg_reg  <= c_neg_reg;
        d_last_reg <= c_last_reg;
        mag_reg    <= mag_next;
        e_neg_reg  <= d_neg_reg;
        e_last_reg <= d_last_reg;
        act_reg    <= act_next;
        last_reg   <= e_last_reg;
    end

    assign done       = done_reg;
    assign activation = act_reg;
    assign last_out   = last_reg;

    // Non-negative f always gives Phi of at least one half
    a_phi_half: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && !a_side_reg.neg |-> phi_reg >= PHI_HALF)
        else $error("Phi below one half for non-negative input");

    a_clamp_window: assert property (@(posedge clk) disable iff (!rst_n)
        done && (clamp_low <= clamp_high) |->
            (activation >= clamp_low) && (activation <= clamp_high))
        else $error("result outside clamp window");

endmodule

@@ sv/int8_gelu_activation_unit.sv @@
// ----------------------------------------------------------------------------
// int8_gelu_activation_unit
// Each request passes front, Horner, divider, squaring and requant stages to done.
// Throughput: one request per cycle; busy never rises, the pipeline has no stalls.
// Results cannot be held off; done lasts exactly one cycle per request.
// Reset clears the valid bits and loads the default scales and clamp bounds.
// ----------------------------------------------------------------------------
module int8_gelu_activation_unit
    import igelu_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [SAMPLE_W-1:0]  sample,
    input  logic                        last_in,
    output logic                        done,
    output logic signed [ACT_W-1:0]     activation,
    output logic                        last_out,
    input  logic                        cfg_write,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [SCALE_W-1:0]          cfg_data
);

    logic [SCALE_W-1:0]        input_scale_reg;
    logic [SCALE_W-1:0]        inv_out_scale_reg;
    logic signed [CLAMP_W-1:0] clamp_low_reg;
    logic signed [CLAMP_W-1:0] clamp_high_reg;

    logic                      accept;

    logic                      front_valid;
    logic [Z_W-1:0]            front_z;
    igelu_side_t               front_side;
    logic                      poly_valid;
    logic [P_W-1:0]            poly_value;
    igelu_side_t               poly_side;
    logic                      recip_valid;
    logic [R_W-1:0]            recip_value;
    igelu_side_t               recip_side;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_scale_reg   <= INPUT_SCALE_RST;
            inv_out_scale_reg <= INV_OUT_SCALE_RST;
            clamp_low_reg     <= CLAMP_LOW_RST;
            clamp_high_reg    <= CLAMP_HIGH_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_INPUT_SCALE:   input_scale_reg   <= cfg_data;
                CFG_INV_OUT_SCALE: inv_out_scale_reg <= cfg_data;
                CFG_CLAMP_LOW:     clamp_low_reg     <= cfg_data[CLAMP_W-1:0];
                CFG_CLAMP_HIGH:    clamp_high_reg    <= cfg_data[CLAMP_W-1:0];
                default:           ;
            endcase
        end
    end

    // fully pipelined: a request is taken every cycle
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    igelu_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (accept),
        .sample      (sample),
        .last_in     (last_in),
        .input_scale (input_scale_reg),
        .out_valid   (front_valid),
        .z           (front_z),
        .side        (front_side)
    );

    igelu_poly u_poly (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .z         (front_z),
        .side_in   (front_side),
        .out_valid (poly_valid),
        .poly      (poly_value),
        .side_out  (poly_side)
    );

    igelu_recip u_recip (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (poly_valid),
        .poly      (poly_value),
        .side_in   (poly_side),
        .out_valid (recip_valid),
        .recip16   (recip_value),
        .side_out  (recip_side)
    );

    igelu_requant u_requant (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_valid             (recip_valid),
        .recip16              (recip_value),
        .side_in              (recip_side),
        .inverse_output_scale (inv_out_scale_reg),
        .clamp_low            (clamp_low_reg),
        .clamp_high           (clamp_high_reg),
        .done                 (done),
        .activation           (activation),
        .last_out             (last_out)
    );

    a_done_follows_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result without a matching request");

endmodule
